// ----- rtl/lst_pkg.sv -----
// shared types, token kind codes and keyword tables for the lox source tokenizer
// no dependencies
package lst_pkg;

	localparam int MAX_SOURCE_LEN_DEF = 65536;
	localparam int TOK_PER_ITEM = 4;
	localparam int QDEPTH = 4;
	localparam int NUM_KW = 18;

	localparam logic [5:0] K_LPAREN = 6'd0;
	localparam logic [5:0] K_RPAREN = 6'd1;
	localparam logic [5:0] K_LBRACE = 6'd2;
	localparam logic [5:0] K_RBRACE = 6'd3;
	localparam logic [5:0] K_COMMA = 6'd4;
	localparam logic [5:0] K_DOT = 6'd5;
	localparam logic [5:0] K_MINUS = 6'd6;
	localparam logic [5:0] K_PLUS = 6'd7;
	localparam logic [5:0] K_SEMI = 6'd8;
	localparam logic [5:0] K_SLASH = 6'd9;
	localparam logic [5:0] K_STAR = 6'd10;
	localparam logic [5:0] K_QUEST = 6'd11;
	localparam logic [5:0] K_COLON = 6'd12;
	localparam logic [5:0] K_BANG = 6'd13;
	localparam logic [5:0] K_EQUAL = 6'd15;
	localparam logic [5:0] K_GREATER = 6'd17;
	localparam logic [5:0] K_LESS = 6'd19;
	localparam logic [5:0] K_IDENT = 6'd21;
	localparam logic [5:0] K_STRING = 6'd22;
	localparam logic [5:0] K_NUMBER = 6'd23;
	localparam logic [5:0] K_KW0 = 6'd24;
	localparam logic [5:0] K_EOF = 6'd42;
	localparam logic [5:0] K_BADCH = 6'd43;
	localparam logic [5:0] K_UNTERM = 6'd44;

	localparam logic [63:0] KW_TEXT [NUM_KW] = '{
		64'("and"), 64'("class"), 64'("else"), 64'("false"), 64'("for"),
		64'("fun"), 64'("if"), 64'("nil"), 64'("or"), 64'("print"),
		64'("return"), 64'("super"), 64'("this"), 64'("true"), 64'("var"),
		64'("while"), 64'("break"), 64'("continue")};
	localparam logic [3:0] KW_LEN [NUM_KW] = '{
		4'd3, 4'd5, 4'd4, 4'd5, 4'd3, 4'd3, 4'd2, 4'd3, 4'd2,
		4'd5, 4'd6, 4'd5, 4'd4, 4'd4, 4'd3, 4'd5, 4'd5, 4'd8};

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
		logic [15:0] line;
	} tok_t;

	typedef struct packed {
		tok_t [TOK_PER_ITEM-1:0] tok;
		logic [2:0]              cnt;
	} bundle_t;

endpackage

// ----- rtl/lst_front.sv -----
// front end: accepts source bytes, runs the scanner state and builds a token bundle per item
// depends on lst_pkg
module lst_front #(
	parameter int MAX_SOURCE_LEN = lst_pkg::MAX_SOURCE_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       ch,
	input  logic             has_char,
	input  logic             end_of_source,
	output logic             push,
	output lst_pkg::bundle_t push_data
);

	localparam logic [15:0] POS_CAP = (MAX_SOURCE_LEN > 65535) ? 16'hFFFF :
		16'(MAX_SOURCE_LEN);

	typedef enum logic [3:0] {
		M_IDLE, M_LINEC, M_BLOCK, M_BSTAR, M_STR, M_IDENT, M_INT, M_NDOT, M_FRAC, M_PEND
	} mode_t;

	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_BANG = 3'd1;
	localparam logic [2:0] OP_EQ = 3'd2;
	localparam logic [2:0] OP_LT = 3'd3;
	localparam logic [2:0] OP_GT = 3'd4;
	localparam logic [2:0] OP_SL = 3'd5;

	mode_t       mode_q, mode_d;
	logic [2:0]  pend_q, pend_d;
	logic [15:0] ss_q, ss_d;
	logic [15:0] pos_q, pos_d;
	logic [15:0] line_q, line_d;
	logic [17:0] kc_q, kc_d;
	logic [3:0]  il_q, il_d;
	lst_pkg::bundle_t b;

	function automatic lst_pkg::bundle_t add(lst_pkg::bundle_t bi, logic [5:0] kind,
		logic [15:0] s, logic [15:0] e, logic [15:0] ln);
		lst_pkg::bundle_t bo;
		bo = bi;
		if (bi.cnt < 3'(lst_pkg::TOK_PER_ITEM)) begin
			bo.tok[bi.cnt[1:0]].kind = kind;
			bo.tok[bi.cnt[1:0]].start = s;
			bo.tok[bi.cnt[1:0]].len = (e > s) ? e - s : 16'd0;
			bo.tok[bi.cnt[1:0]].line = ln;
			bo.cnt = bi.cnt + 3'd1;
		end
		return bo;
	endfunction

	function automatic logic [5:0] ident_kind(logic [17:0] kc, logic [3:0] il);
		logic [5:0] kind;
		kind = lst_pkg::K_IDENT;
		for (int k = 0; k < lst_pkg::NUM_KW; k++)
			if (kc[k] && lst_pkg::KW_LEN[k] == il)
				kind = lst_pkg::K_KW0 + 6'(k);
		return kind;
	endfunction

	function automatic logic [5:0] op_single(logic [2:0] op);
		logic [5:0] kind;
		unique case (op)
			OP_BANG: kind = lst_pkg::K_BANG;
			OP_EQ:   kind = lst_pkg::K_EQUAL;
			OP_LT:   kind = lst_pkg::K_LESS;
			OP_GT:   kind = lst_pkg::K_GREATER;
			default: kind = 6'd0;
		endcase
		return kind;
	endfunction

	always_comb begin
		logic [15:0] p, pn, d;
		logic        redo, dig, alp;
		int          idx;
		b = '0;
		mode_d = mode_q;
		pend_d = pend_q;
		ss_d = ss_q;
		pos_d = pos_q;
		line_d = line_q;
		kc_d = kc_q;
		il_d = il_q;
		p = pos_q;
		pn = (pos_q < POS_CAP) ? pos_q + 16'd1 : POS_CAP;
		d = (p > 16'd0) ? p - 16'd1 : 16'd0;
		redo = 1'b0;
		dig = (ch >= "0") && (ch <= "9");
		alp = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z")) || (ch == "_");
		idx = 0;
		if (has_char) begin
			unique case (mode_q)
				M_LINEC: if (ch == 8'h0A) begin
					mode_d = M_IDLE;
					redo = 1'b1;
				end
				M_BLOCK: begin
					if (ch == "*") mode_d = M_BSTAR;
					else if (ch == 8'h0A && line_d != 16'hFFFF) line_d = line_d + 16'd1;
				end
				M_BSTAR: begin
					if (ch == "/") mode_d = M_IDLE;
					else if (ch == 8'h0A) begin
						if (line_d != 16'hFFFF) line_d = line_d + 16'd1;
						mode_d = M_BLOCK;
					end else if (ch != "*") mode_d = M_BLOCK;
				end
				M_STR: begin
					if (ch == "\"") begin
						b = add(b, lst_pkg::K_STRING, ss_d, pn, line_d);
						mode_d = M_IDLE;
					end else if (ch == 8'h0A && line_d != 16'hFFFF) line_d = line_d + 16'd1;
				end
				M_IDENT: begin
					if (alp || dig) begin
						for (int k = 0; k < lst_pkg::NUM_KW; k++) begin
							idx = (int'(lst_pkg::KW_LEN[k]) - 1 - int'(il_q)) * 8;
							if (!(il_q < lst_pkg::KW_LEN[k] &&
								lst_pkg::KW_TEXT[k][idx[5:0] +: 8] == ch))
								kc_d[k] = 1'b0;
						end
						if (il_q < 4'd15) il_d = il_q + 4'd1;
					end else begin
						b = add(b, ident_kind(kc_q, il_q), ss_d, p, line_d);
						mode_d = M_IDLE;
						redo = 1'b1;
					end
				end
				M_INT: begin
					if (ch == ".") mode_d = M_NDOT;
					else if (!dig) begin
						b = add(b, lst_pkg::K_NUMBER, ss_d, p, line_d);
						mode_d = M_IDLE;
						redo = 1'b1;
					end
				end
				M_NDOT: begin
					if (dig) mode_d = M_FRAC;
					else begin
						b = add(b, lst_pkg::K_NUMBER, ss_d, d, line_d);
						b = add(b, lst_pkg::K_DOT, d, p, line_d);
						mode_d = M_IDLE;
						redo = 1'b1;
					end
				end
				M_FRAC: if (!dig) begin
					b = add(b, lst_pkg::K_NUMBER, ss_d, p, line_d);
					mode_d = M_IDLE;
					redo = 1'b1;
				end
				M_PEND: begin
					if (pend_q == OP_SL) begin
						if (ch == "/") mode_d = M_LINEC;
						else if (ch == "*") mode_d = M_BLOCK;
						else begin
							b = add(b, lst_pkg::K_SLASH, ss_d, p, line_d);
							mode_d = M_IDLE;
							redo = 1'b1;
						end
					end else if (ch == "=") begin
						b = add(b, op_single(pend_q) + 6'd1, ss_d, pn, line_d);
						mode_d = M_IDLE;
					end else begin
						b = add(b, op_single(pend_q), ss_d, p, line_d);
						mode_d = M_IDLE;
						redo = 1'b1;
					end
					if (mode_d == M_IDLE) pend_d = OP_NONE;
				end
				default: begin
					mode_d = M_IDLE;
					redo = 1'b1;
				end
			endcase
			if (redo) begin
				unique case (ch)
					"(": b = add(b, lst_pkg::K_LPAREN, p, pn, line_d);
					")": b = add(b, lst_pkg::K_RPAREN, p, pn, line_d);
					"{": b = add(b, lst_pkg::K_LBRACE, p, pn, line_d);
					"}": b = add(b, lst_pkg::K_RBRACE, p, pn, line_d);
					",": b = add(b, lst_pkg::K_COMMA, p, pn, line_d);
					".": b = add(b, lst_pkg::K_DOT, p, pn, line_d);
					"-": b = add(b, lst_pkg::K_MINUS, p, pn, line_d);
					"+": b = add(b, lst_pkg::K_PLUS, p, pn, line_d);
					";": b = add(b, lst_pkg::K_SEMI, p, pn, line_d);
					"*": b = add(b, lst_pkg::K_STAR, p, pn, line_d);
					"?": b = add(b, lst_pkg::K_QUEST, p, pn, line_d);
					":": b = add(b, lst_pkg::K_COLON, p, pn, line_d);
					"!": begin mode_d = M_PEND; pend_d = OP_BANG; ss_d = p; end
					"=": begin mode_d = M_PEND; pend_d = OP_EQ; ss_d = p; end
					"<": begin mode_d = M_PEND; pend_d = OP_LT; ss_d = p; end
					">": begin mode_d = M_PEND; pend_d = OP_GT; ss_d = p; end
					"/": begin mode_d = M_PEND; pend_d = OP_SL; ss_d = p; end
					" ", 8'h0D, 8'h09: ;
					8'h0A: if (line_d != 16'hFFFF) line_d = line_d + 16'd1;
					"\"": begin mode_d = M_STR; ss_d = p; end
					default: begin
						if (dig) begin
							mode_d = M_INT;
							ss_d = p;
						end else if (alp) begin
							mode_d = M_IDENT;
							ss_d = p;
							il_d = 4'd1;
							for (int k = 0; k < lst_pkg::NUM_KW; k++) begin
								idx = (int'(lst_pkg::KW_LEN[k]) - 1) * 8;
								kc_d[k] = (lst_pkg::KW_TEXT[k][idx[5:0] +: 8] == ch);
							end
						end else begin
							b = add(b, lst_pkg::K_BADCH, p, pn, line_d);
						end
					end
				endcase
			end
			pos_d = pn;
		end
		if (end_of_source) begin
			p = pos_d;
			d = (p > 16'd0) ? p - 16'd1 : 16'd0;
			unique case (mode_d)
				M_IDENT: b = add(b, ident_kind(kc_d, il_d), ss_d, p, line_d);
				M_INT, M_FRAC: b = add(b, lst_pkg::K_NUMBER, ss_d, p, line_d);
				M_NDOT: begin
					b = add(b, lst_pkg::K_NUMBER, ss_d, d, line_d);
					b = add(b, lst_pkg::K_DOT, d, p, line_d);
				end
				M_PEND: begin
					if (pend_d == OP_SL) b = add(b, lst_pkg::K_SLASH, ss_d, p, line_d);
					else b = add(b, op_single(pend_d), ss_d, p, line_d);
				end
				M_STR: b = add(b, lst_pkg::K_UNTERM, ss_d, p, line_d);
				default: ;
			endcase
			b = add(b, lst_pkg::K_EOF, p, p, line_d);
			mode_d = M_IDLE;
			pend_d = OP_NONE;
			ss_d = '0;
			pos_d = '0;
			line_d = 16'd1;
			kc_d = '0;
			il_d = '0;
		end
	end

	assign push = take && (b.cnt != 3'd0);
	assign push_data = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pend_q <= OP_NONE;
			ss_q <= '0;
			pos_q <= '0;
			line_q <= 16'd1;
			kc_q <= '0;
			il_q <= '0;
		end else if (take) begin
			mode_q <= mode_d;
			pend_q <= pend_d;
			ss_q <= ss_d;
			pos_q <= pos_d;
			line_q <= line_d;
			kc_q <= kc_d;
			il_q <= il_d;
		end
	end

endmodule

// ----- rtl/lst_queue.sv -----
// short bundle queue between front and back ends
// depends on lst_pkg
module lst_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lst_pkg::bundle_t push_data,
	input  logic             pop,
	output lst_pkg::bundle_t pop_data,
	output logic             full,
	output logic             nonempty
);

	localparam int AW = $clog2(lst_pkg::QDEPTH);

	lst_pkg::bundle_t mem_q [lst_pkg::QDEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      cnt_q;

	assign full = (cnt_q == (AW+1)'(lst_pkg::QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + AW'(1);
			if (pop) rd_q <= rd_q + AW'(1);
			if (push && !pop) cnt_q <= cnt_q + (AW+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (AW+1)'(1);
		end
	end

endmodule

// ----- rtl/lst_back.sv -----
// back end: holds one bundle and hands out its tokens one transaction at a time
// depends on lst_pkg
module lst_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             avail,
	input  lst_pkg::bundle_t next,
	output logic             pop,
	output logic             valid,
	input  logic             ready,
	output lst_pkg::tok_t    tok,
	output logic             last
);

	lst_pkg::bundle_t bun_q;
	logic [1:0]       idx_q;
	logic             valid_q;

	assign valid = valid_q;
	assign tok = bun_q.tok[idx_q];
	assign last = ({1'b0, idx_q} == bun_q.cnt - 3'd1);
	assign pop = avail && (!valid_q || (ready && last));

	always_ff @(posedge clk) begin
		if (pop) bun_q <= next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			valid_q <= 1'b0;
		end else if (pop) begin
			idx_q <= '0;
			valid_q <= 1'b1;
		end else if (valid_q && ready) begin
			idx_q <= idx_q + 2'd1;
			if (last) valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/lox_source_tokenizer.sv -----
// Lox source tokenizer: takes one source byte per transaction and streams out tokens
// (kind, start, length, line). A byte is accepted every cycle while the four-entry
// bundle queue has room; each byte yields zero to four tokens, and the output side
// delivers one token per cycle while m_tready is high, so input keeps pace as long as
// tokens average at most one per byte; otherwise the token output sets the pace.
// depends on lst_pkg, lst_front, lst_queue, lst_back
module lox_source_tokenizer #(
	parameter int MAX_SOURCE_LEN = lst_pkg::MAX_SOURCE_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // ch
	input  logic        s_tuser,  // has_char
	input  logic        s_tlast,  // end_of_source
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // token_start, token_length, token_line
	output logic [5:0]  m_tuser,  // token_kind
	output logic        m_tlast   // last_of_run
);

	logic             take, push, pop, full, nonempty;
	lst_pkg::bundle_t push_data, pop_data;
	lst_pkg::tok_t    tok;

	assign s_tready = !full;
	assign take = s_tvalid && s_tready;

	lst_front #(.MAX_SOURCE_LEN(MAX_SOURCE_LEN)) u_front (
		.clk, .arst_n, .take,
		.ch(s_tdata), .has_char(s_tuser), .end_of_source(s_tlast),
		.push, .push_data
	);

	lst_queue u_queue (
		.clk, .arst_n, .push, .push_data, .pop, .pop_data, .full, .nonempty
	);

	lst_back u_back (
		.clk, .arst_n, .avail(nonempty), .next(pop_data), .pop,
		.valid(m_tvalid), .ready(m_tready), .tok, .last(m_tlast)
	);

	assign m_tdata = {tok.line, tok.len, tok.start};
	assign m_tuser = tok.kind;

endmodule

// ----- tb/lox_source_tokenizer_tb.sv -----
// self-checking testbench for lox_source_tokenizer: directed and random source texts,
// a local token predictor, random stalls on both stream sides
// depends on lst_pkg and the tokenizer rtl
module lox_source_tokenizer_tb;

	localparam int MODE_IDLE = 0;
	localparam int MODE_LINEC = 1;
	localparam int MODE_BLOCK = 2;
	localparam int MODE_BSTAR = 3;
	localparam int MODE_STR = 4;
	localparam int MODE_IDENT = 5;
	localparam int MODE_INT = 6;
	localparam int MODE_NDOT = 7;
	localparam int MODE_FRAC = 8;
	localparam int MODE_PEND = 9;
	localparam int OP_NONE = 0;
	localparam int OP_BANG = 1;
	localparam int OP_EQ = 2;
	localparam int OP_LT = 3;
	localparam int OP_GT = 4;
	localparam int OP_SLASH = 5;
	localparam int POS_CAP = 65535;

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
		logic [15:0] line;
		logic        last;
	} token_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [5:0]  m_tuser;
	logic        m_tlast;

	token_t expected_tokens[$];
	int     errors;
	int     tokens_seen;
	int     bytes_sent;
	int     texts_sent;
	int     out_gap;

	int          scan_mode;
	int          pend_op;
	int          span_start;
	int          byte_pos;
	int          line_no;
	logic [17:0] kw_mask;
	int          id_len;
	int          burst;

	lox_source_tokenizer dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("timeout at %0t", $time);
		$display("lox_source_tokenizer verification failed");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic bit is_digit(int c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(int c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic [7:0] kw_char(int k, int i);
		return lst_pkg::KW_TEXT[k][8*(lst_pkg::KW_LEN[k]-1-i) +: 8];
	endfunction

	function automatic void reset_scanner();
		scan_mode = MODE_IDLE;
		pend_op = OP_NONE;
		span_start = 0;
		byte_pos = 0;
		line_no = 1;
		kw_mask = '0;
		id_len = 0;
	endfunction

	function automatic void push_token(int kind, int s, int e);
		token_t t;
		t.kind = 6'(kind);
		t.start = 16'(s);
		t.len = (e > s) ? 16'(e - s) : 16'd0;
		t.line = 16'(line_no);
		t.last = 0;
		expected_tokens.insert(expected_tokens.size(), t);
		burst++;
	endfunction

	function automatic void bump_line();
		if (line_no < 65535) line_no++;
	endfunction

	function automatic void push_ident(int e);
		int kind;
		kind = lst_pkg::K_IDENT;
		for (int k = 0; k < lst_pkg::NUM_KW; k++)
			if (kw_mask[k] && lst_pkg::KW_LEN[k] == id_len) kind = lst_pkg::K_KW0 + k;
		push_token(kind, span_start, e);
	endfunction

	function automatic int op_kind(int op);
		case (op)
			OP_BANG: return lst_pkg::K_BANG;
			OP_EQ: return lst_pkg::K_EQUAL;
			OP_LT: return lst_pkg::K_LESS;
			OP_GT: return lst_pkg::K_GREATER;
			default: return lst_pkg::K_SLASH;
		endcase
	endfunction

	function automatic void scan_idle(int c, int p, int pn);
		scan_mode = MODE_IDLE;
		case (c)
			"(": push_token(lst_pkg::K_LPAREN, p, pn);
			")": push_token(lst_pkg::K_RPAREN, p, pn);
			"{": push_token(lst_pkg::K_LBRACE, p, pn);
			"}": push_token(lst_pkg::K_RBRACE, p, pn);
			",": push_token(lst_pkg::K_COMMA, p, pn);
			".": push_token(lst_pkg::K_DOT, p, pn);
			"-": push_token(lst_pkg::K_MINUS, p, pn);
			"+": push_token(lst_pkg::K_PLUS, p, pn);
			";": push_token(lst_pkg::K_SEMI, p, pn);
			"*": push_token(lst_pkg::K_STAR, p, pn);
			"?": push_token(lst_pkg::K_QUEST, p, pn);
			":": push_token(lst_pkg::K_COLON, p, pn);
			"!": begin scan_mode = MODE_PEND; pend_op = OP_BANG; span_start = p; end
			"=": begin scan_mode = MODE_PEND; pend_op = OP_EQ; span_start = p; end
			"<": begin scan_mode = MODE_PEND; pend_op = OP_LT; span_start = p; end
			">": begin scan_mode = MODE_PEND; pend_op = OP_GT; span_start = p; end
			"/": begin scan_mode = MODE_PEND; pend_op = OP_SLASH; span_start = p; end
			" ", 13, 9: ;
			10: bump_line();
			"\"": begin scan_mode = MODE_STR; span_start = p; end
			default: begin
				if (is_digit(c)) begin
					scan_mode = MODE_INT;
					span_start = p;
				end else if (is_alpha(c)) begin
					scan_mode = MODE_IDENT;
					span_start = p;
					id_len = 1;
					for (int k = 0; k < lst_pkg::NUM_KW; k++) kw_mask[k] = (kw_char(k, 0) == c);
				end else begin
					push_token(lst_pkg::K_BADCH, p, pn);
				end
			end
		endcase
	endfunction

	function automatic void scan_byte(int c);
		int p;
		int pn;
		int d;
		bit again;
		p = byte_pos;
		pn = (p < POS_CAP) ? p + 1 : POS_CAP;
		do begin
			again = 0;
			case (scan_mode)
				MODE_LINEC: if (c == 10) begin scan_mode = MODE_IDLE; again = 1; end
				MODE_BLOCK: begin
					if (c == "*") scan_mode = MODE_BSTAR;
					else if (c == 10) bump_line();
				end
				MODE_BSTAR: begin
					if (c == "/") scan_mode = MODE_IDLE;
					else if (c == 10) begin bump_line(); scan_mode = MODE_BLOCK; end
					else if (c != "*") scan_mode = MODE_BLOCK;
				end
				MODE_STR: begin
					if (c == "\"") begin
						push_token(lst_pkg::K_STRING, span_start, pn);
						scan_mode = MODE_IDLE;
					end else if (c == 10) bump_line();
				end
				MODE_IDENT: begin
					if (is_alpha(c) || is_digit(c)) begin
						for (int k = 0; k < lst_pkg::NUM_KW; k++)
							if (kw_mask[k] && !(id_len < lst_pkg::KW_LEN[k] &&
									kw_char(k, id_len) == c))
								kw_mask[k] = 0;
						if (id_len < 15) id_len++;
					end else begin
						push_ident(p);
						scan_mode = MODE_IDLE;
						again = 1;
					end
				end
				MODE_INT: begin
					if (c == ".") scan_mode = MODE_NDOT;
					else if (!is_digit(c)) begin
						push_token(lst_pkg::K_NUMBER, span_start, p);
						scan_mode = MODE_IDLE;
						again = 1;
					end
				end
				MODE_NDOT: begin
					if (is_digit(c)) scan_mode = MODE_FRAC;
					else begin
						d = (p > 0) ? p - 1 : 0;
						push_token(lst_pkg::K_NUMBER, span_start, d);
						push_token(lst_pkg::K_DOT, d, p);
						scan_mode = MODE_IDLE;
						again = 1;
					end
				end
				MODE_FRAC: begin
					if (!is_digit(c)) begin
						push_token(lst_pkg::K_NUMBER, span_start, p);
						scan_mode = MODE_IDLE;
						again = 1;
					end
				end
				MODE_PEND: begin
					if (pend_op == OP_SLASH) begin
						if (c == "/") scan_mode = MODE_LINEC;
						else if (c == "*") scan_mode = MODE_BLOCK;
						else begin
							push_token(lst_pkg::K_SLASH, span_start, p);
							scan_mode = MODE_IDLE;
							again = 1;
						end
					end else if (c == "=") begin
						push_token(op_kind(pend_op) + 1, span_start, pn);
						scan_mode = MODE_IDLE;
					end else begin
						push_token(op_kind(pend_op), span_start, p);
						scan_mode = MODE_IDLE;
						again = 1;
					end
					if (scan_mode == MODE_IDLE) pend_op = OP_NONE;
				end
				default: scan_idle(c, p, pn);
			endcase
		end while (again);
		byte_pos = pn;
	endfunction

	function automatic void flush_source();
		int p;
		int d;
		p = byte_pos;
		d = (p > 0) ? p - 1 : 0;
		case (scan_mode)
			MODE_IDENT: push_ident(p);
			MODE_INT, MODE_FRAC: push_token(lst_pkg::K_NUMBER, span_start, p);
			MODE_NDOT: begin
				push_token(lst_pkg::K_NUMBER, span_start, d);
				push_token(lst_pkg::K_DOT, d, p);
			end
			MODE_PEND: push_token(op_kind(pend_op), span_start, p);
			MODE_STR: push_token(lst_pkg::K_UNTERM, span_start, p);
			default: ;
		endcase
		push_token(lst_pkg::K_EOF, p, p);
		reset_scanner();
	endfunction

	function automatic void predict_item(logic [7:0] c, logic has, logic fin);
		token_t t;
		burst = 0;
		if (has) scan_byte(c);
		if (fin) flush_source();
		if (burst > 0) begin
			t = expected_tokens.pop_back();
			t.last = 1;
			expected_tokens.insert(expected_tokens.size(), t);
		end
	endfunction

	task automatic send_item(logic [7:0] c, logic has, logic fin);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= c;
		s_tuser <= has;
		s_tlast <= fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_item(c, has, fin);
		bytes_sent++;
		if (fin) texts_sent++;
	endtask

	task automatic send_text(string text, bit end_only);
		for (int i = 0; i < text.len(); i++)
			send_item(text[i], 1, (!end_only && i == text.len() - 1));
		if (end_only || text.len() == 0) send_item(8'($urandom), 0, 1);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_gap > 0) begin
				m_tready <= 0;
				out_gap <= out_gap - 1;
			end else begin
				m_tready <= 1;
				out_gap <= gap_len();
			end
		end
	end

	always @(posedge clk) begin
		token_t e;
		if (arst_n && m_tvalid && m_tready) begin
			tokens_seen++;
			if (expected_tokens.size() == 0) begin
				$display("%0t unexpected token kind %0d", $time, m_tuser);
				errors++;
			end else begin
				e = expected_tokens.pop_front();
				if (m_tuser !== e.kind || m_tdata[15:0] !== e.start ||
						m_tdata[31:16] !== e.len || m_tdata[47:32] !== e.line ||
						m_tlast !== e.last) begin
					$display("%0t mismatch exp kind %0d start %0d len %0d line %0d last %0d",
						$time, e.kind, e.start, e.len, e.line, e.last);
					$display("%0t          got kind %0d start %0d len %0d line %0d last %0d",
						$time, m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
						m_tlast);
					errors++;
				end
			end
		end
	end

	task automatic test_punctuation();
		send_text("(){},.-+;*?:/", 0);
		send_text("! != = == < <= > >= !", 1);
	endtask

	task automatic test_literals();
		send_text("x1 = 12.5 + 7. + 3 \"ab\ncd\" _q", 0);
		send_text("1.", 1);
		send_text("\"never closed", 1);
	endtask

	task automatic test_keywords();
		send_text("and class else false for fun if nil or print return super", 0);
		send_text("this true var while break continue an classy contin", 0);
	endtask

	task automatic test_comments_and_odd_bytes();
		send_text("a // skip\n/* b\n** */ c /* open", 1);
		send_item(8'h00, 1, 0);
		send_item(8'hff, 1, 0);
		send_item(8'h80, 0, 0);
		send_item(8'h23, 1, 1);
		send_text("", 1);
	endtask

	task automatic test_random_sources();
		string frags[] = '{"var", "while", "print", "foo", "_x9", "42", "3.14", "9.",
			"\"s t\"", "// c\n", "/* m\n*/", " ", "\n", "\t", "==", "!=", "<=",
			">=", "=", "<", ">", "!", "/", "(", ")", "{", "}", ";", ",", ".", "+",
			"-", "*", "?", ":", "\r", "true", "nil", "returnx", "breaker"};
		string s;
		int r;
		while (bytes_sent < 340) begin
			s = "";
			repeat ($urandom_range(1, 10)) begin
				r = $urandom_range(0, 99);
				if (r < 85) s = {s, frags[$urandom_range(0, frags.size() - 1)]};
				else if (r < 92) s = {s, string'(byte'($urandom_range(0, 255)))};
				else s = {s, "\""};
			end
			if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 0, 0);
			send_text(s, $urandom_range(0, 1));
		end
	endtask

	initial begin
		int waited;
		errors = 0;
		tokens_seen = 0;
		bytes_sent = 0;
		texts_sent = 0;
		out_gap = 0;
		reset_scanner();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = 0;
		s_tlast = 0;
		m_tready = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_punctuation();
		test_literals();
		test_keywords();
		test_comments_and_odd_bytes();
		test_random_sources();
		s_tvalid <= 0;
		waited = 0;
		while (expected_tokens.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (expected_tokens.size() != 0) begin
			$display("%0t %0d expected tokens never arrived", $time, expected_tokens.size());
			errors++;
		end
		$display("sent %0d items in %0d source texts, checked %0d tokens",
			bytes_sent, texts_sent, tokens_seen);
		if (errors == 0) begin
			$display("lox_source_tokenizer verification clean");
		end else begin
			$display("lox_source_tokenizer verification failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/lst_pkg.sv
rtl/lst_front.sv
rtl/lst_queue.sv
rtl/lst_back.sv
rtl/lox_source_tokenizer.sv
tb/lox_source_tokenizer_tb.sv
